// ----- sv/lottery_ticket_scheduler_top_macros.svh -----
// Assertion macros shared by the lottery ticket scheduler.
`ifndef LOTTERY_TICKET_SCHEDULER_TOP_MACROS_SVH
`define LOTTERY_TICKET_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lts_pkg.sv -----
// Types, constants and codes for the lottery ticket scheduler.
package lts_pkg;

  localparam int MAX_TASKS   = 64;
  localparam int TICKET_BITS = 16;
  localparam int IDX_W       = $clog2(MAX_TASKS);
  localparam int CNT_W       = 7;
  localparam int ID_W        = 16;
  localparam int SUM_W       = 22;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_DRAW   = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_RANGE     = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] tickets;
    logic [15:0] task_id;
    logic [21:0] winning_ticket;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result_id;
    logic [1:0]  status;
    logic [6:0]  task_count;
    logic [21:0] total_tickets;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]        id;
    logic [TICKET_BITS-1:0] tk;
  } entry_t;

  // Command under work, latched at accept.
  typedef struct packed {
    logic [1:0]             cmd;
    logic [ID_W-1:0]        key;
    logic [TICKET_BITS-1:0] tk;
    logic [SUM_W-1:0]       win;
    logic [CNT_W-1:0]       count;
    logic                   add_ok;
    logic [ID_W-1:0]        new_id;
  } op_t;

  // Sweep outcome from the head unit.
  typedef struct packed {
    logic                   hit;
    logic                   found;
    logic [ID_W-1:0]        win_id;
    logic [TICKET_BITS-1:0] rm_tk;
  } head_res_t;

endpackage

// ----- sv/lts_cell.sv -----
// One table slot of the rotating task chain.
module lts_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  lts_pkg::entry_t nb_in,
  output lts_pkg::entry_t q
);

  lts_pkg::entry_t q_r;

  // Take the neighbor's entry on every rotation step
  always_ff @(posedge clk) begin
    if (shift_en) begin
      q_r <= nb_in;
    end
  end

  assign q = q_r;

endmodule

// ----- sv/lts_head.sv -----
// Head unit: inspects the entry leaving the chain and decides what re-enters at the tail.
module lts_head (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    step_en,
  input  logic [lts_pkg::IDX_W-1:0] step,
  input  lts_pkg::op_t            op,
  input  lts_pkg::entry_t         head_e,
  input  lts_pkg::entry_t         next_e,
  output lts_pkg::entry_t         tail_e,
  output lts_pkg::head_res_t      res
);

  logic                              hit_r, hit_nxt;
  logic                              found_r, found_nxt;
  logic [lts_pkg::SUM_W-1:0]         acc_r, acc_nxt;
  logic [lts_pkg::ID_W-1:0]          win_id_r, win_id_nxt;
  logic [lts_pkg::TICKET_BITS-1:0]   rm_tk_r, rm_tk_nxt;
  logic                              live;
  logic                              match;
  logic                              hit_now;
  logic                              add_here;
  logic                              win_here;
  logic [lts_pkg::SUM_W-1:0]         sum_here;

  assign live     = (lts_pkg::CNT_W'(step) < op.count);
  assign match    = (op.cmd == lts_pkg::CMD_REMOVE) && live && !hit_r && (head_e.id == op.key);
  assign hit_now  = hit_r || match;
  assign add_here = (op.cmd == lts_pkg::CMD_ADD) && op.add_ok &&
                    (lts_pkg::CNT_W'(step) == op.count);
  assign sum_here = acc_r + lts_pkg::SUM_W'(head_e.tk);
  assign win_here = (op.cmd == lts_pkg::CMD_DRAW) && live && !found_r && (op.win < sum_here);

  // Append the new task, skip over the removed one, or pass the entry through
  always_comb begin
    if (add_here) begin
      tail_e.id = op.new_id;
      tail_e.tk = op.tk;
    end else if (hit_now) begin
      tail_e = next_e;
    end else begin
      tail_e = head_e;
    end
  end

  // Advance sweep state
  always_comb begin
    hit_nxt    = hit_now;
    found_nxt  = found_r || win_here;
    acc_nxt    = live ? sum_here : acc_r;
    win_id_nxt = win_here ? head_e.id : win_id_r;
    rm_tk_nxt  = match ? head_e.tk : rm_tk_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      hit_r   <= 1'b0;
      found_r <= 1'b0;
      acc_r   <= '0;
    end else if (step_en) begin
      hit_r   <= hit_nxt;
      found_r <= found_nxt;
      acc_r   <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      win_id_r <= win_id_nxt;
      rm_tk_r  <= rm_tk_nxt;
    end
  end

  assign res.hit    = hit_r;
  assign res.found  = found_r;
  assign res.win_id = win_id_r;
  assign res.rm_tk  = rm_tk_r;

endmodule

// ----- sv/lottery_ticket_scheduler_top.sv -----
// Lottery ticket scheduler: a table of up to MAX_TASKS tasks kept in a rotating chain of
// cells. Every item (add, remove, draw or no-op) rotates the whole chain once through the
// head unit, one cell per cycle: an item goes from accept through MAX_TASKS rotation steps
// to a finish step, which waits while a posted result is still stalled. Ticket ranges are
// implicit running sums formed during the rotation. The result register holds a finished
// item while the next one is taken and rotated.
`include "lottery_ticket_scheduler_top_macros.svh"

module lottery_ticket_scheduler_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lts_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output lts_pkg::out_item_t out_item
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic [lts_pkg::IDX_W-1:0]     step_r, step_nxt;
  logic [lts_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [lts_pkg::SUM_W-1:0]     sum_r, sum_nxt;
  logic [lts_pkg::ID_W-1:0]      id_r, id_nxt;
  lts_pkg::op_t                  op_r, op_nxt;
  logic                          out_valid_r, out_valid_nxt;
  lts_pkg::out_item_t            out_r, out_nxt;
  logic                          accept;
  logic                          step_en;
  logic                          fin_go;
  logic [lts_pkg::TICKET_BITS-1:0] in_tk;
  lts_pkg::entry_t               cell_q [lts_pkg::MAX_TASKS];
  lts_pkg::entry_t               tail_e;
  lts_pkg::head_res_t            hres;

  assign accept  = in_valid && !in_stall;
  assign step_en = (state_r == ST_RUN);
  assign fin_go  = (state_r == ST_FIN) && !(out_valid_r && out_stall);
  assign in_tk   = in_item.tickets[lts_pkg::TICKET_BITS-1:0];

  // Chain of cells, rotating toward cell zero
  for (genvar i = 0; i < lts_pkg::MAX_TASKS; i++) begin : g_cell
    if (i == lts_pkg::MAX_TASKS - 1) begin : g_tail
      lts_cell u_cell (.clk(clk), .shift_en(step_en), .nb_in(tail_e), .q(cell_q[i]));
    end else begin : g_mid
      lts_cell u_cell (.clk(clk), .shift_en(step_en), .nb_in(cell_q[i+1]), .q(cell_q[i]));
    end
  end

  lts_head u_head (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .step_en (step_en),
    .step    (step_r),
    .op      (op_r),
    .head_e  (cell_q[0]),
    .next_e  (cell_q[1]),
    .tail_e  (tail_e),
    .res     (hres)
  );

  // Sequence the item and finish its result
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    id_nxt        = id_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt.cmd    = in_item.command;
          op_nxt.key    = in_item.task_id;
          op_nxt.tk     = in_tk;
          op_nxt.win    = in_item.winning_ticket;
          op_nxt.count  = cnt_r;
          op_nxt.add_ok = (cnt_r < lts_pkg::CNT_W'(lts_pkg::MAX_TASKS)) && (in_tk != '0);
          op_nxt.new_id = id_r + 1'b1;
          step_nxt      = '0;
          state_nxt     = ST_RUN;
        end
      end
      ST_RUN: begin
        step_nxt = step_r + 1'b1;
        if (step_r == lts_pkg::IDX_W'(lts_pkg::MAX_TASKS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          out_nxt.result_id = '0;
          out_nxt.status    = lts_pkg::STAT_OK;
          case (op_r.cmd)
            lts_pkg::CMD_ADD: begin
              if (op_r.add_ok) begin
                out_nxt.result_id = op_r.new_id;
                cnt_nxt           = cnt_r + 1'b1;
                sum_nxt           = sum_r + lts_pkg::SUM_W'(op_r.tk);
                id_nxt            = op_r.new_id;
              end else if (cnt_r >= lts_pkg::CNT_W'(lts_pkg::MAX_TASKS)) begin
                out_nxt.status = lts_pkg::STAT_FULL;
              end else begin
                out_nxt.status = lts_pkg::STAT_RANGE;
              end
            end
            lts_pkg::CMD_REMOVE: begin
              if (hres.hit) begin
                cnt_nxt = cnt_r - 1'b1;
                sum_nxt = sum_r - lts_pkg::SUM_W'(hres.rm_tk);
              end else begin
                out_nxt.status = lts_pkg::STAT_NOT_FOUND;
              end
            end
            lts_pkg::CMD_DRAW: begin
              if (hres.found) begin
                out_nxt.result_id = hres.win_id;
              end else begin
                out_nxt.status = lts_pkg::STAT_RANGE;
              end
            end
            default: begin
              out_nxt.status = lts_pkg::STAT_OK;
            end
          endcase
          out_nxt.task_count    = cnt_nxt;
          out_nxt.total_tickets = sum_nxt;
          out_valid_nxt         = 1'b1;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      id_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      id_r        <= id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    op_r   <= op_nxt;
    out_r  <= out_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `LTS_ASSERT_NEXT(a_accept_runs, accept, state_r == ST_RUN, "accepted item did not start rotation")
  `LTS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= lts_pkg::CNT_W'(lts_pkg::MAX_TASKS), "task count overflow")
  `LTS_ASSERT_NOW(a_out_from_fin, $rose(out_valid_r), $past(state_r) == ST_FIN, "result outside finish")
  `LTS_ASSERT_NEXT(a_fin_idle, fin_go, state_r == ST_IDLE && out_valid_r, "finish did not post result")

endmodule

// ----- verif/lottery_ticket_scheduler_top_tb.sv -----
// Testbench for the lottery ticket scheduler: directed and random commands, predicted results.
`timescale 1ns / 1ps

module lottery_ticket_scheduler_top_tb;

  localparam logic [1:0] CMD_NOP = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  lts_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  lts_pkg::out_item_t out_item;

  lottery_ticket_scheduler_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always #6 clk = ~clk;

  // Shadow copy of the task table
  logic [15:0] tbl_id [lts_pkg::MAX_TASKS];
  logic [15:0] tbl_tk [lts_pkg::MAX_TASKS];
  int          tbl_n;
  logic [21:0] tbl_sum;
  logic [15:0] last_id;

  lts_pkg::in_item_t  pending_items[$];
  lts_pkg::out_item_t expected_results[$];
  bit        failed = 1'b0;
  bit        calm = 1'b0;
  bit        hold_feed = 1'b0;
  bit        feed_done = 1'b0;

  // Apply one command to the shadow table and return its result
  function automatic lts_pkg::out_item_t schedule_step(lts_pkg::in_item_t it);
    lts_pkg::out_item_t r;
    int pos;
    logic [21:0] lo;
    r = '0;
    r.status = lts_pkg::STAT_OK;
    case (it.command)
      lts_pkg::CMD_ADD: begin
        if (tbl_n >= lts_pkg::MAX_TASKS) r.status = lts_pkg::STAT_FULL;
        else if (it.tickets == 0) r.status = lts_pkg::STAT_RANGE;
        else begin
          last_id = last_id + 16'd1;
          tbl_id[tbl_n] = last_id;
          tbl_tk[tbl_n] = it.tickets;
          tbl_n++;
          tbl_sum = tbl_sum + it.tickets;
          r.result_id = last_id;
        end
      end
      lts_pkg::CMD_REMOVE: begin
        pos = -1;
        for (int i = 0; i < tbl_n; i++)
          if (pos < 0 && tbl_id[i] == it.task_id) pos = i;
        if (pos < 0) r.status = lts_pkg::STAT_NOT_FOUND;
        else begin
          tbl_sum = tbl_sum - tbl_tk[pos];
          for (int i = pos; i + 1 < tbl_n; i++) begin
            tbl_id[i] = tbl_id[i+1];
            tbl_tk[i] = tbl_tk[i+1];
          end
          tbl_n--;
        end
      end
      lts_pkg::CMD_DRAW: begin
        if (tbl_n == 0 || it.winning_ticket >= tbl_sum) r.status = lts_pkg::STAT_RANGE;
        else begin
          // Ranges are contiguous, so a linear walk finds the same owner
          lo = '0;
          for (int i = 0; i < tbl_n; i++) begin
            if (r.result_id == 0 && r.status == lts_pkg::STAT_OK &&
                it.winning_ticket >= lo && it.winning_ticket < lo + tbl_tk[i]) begin
              r.result_id = tbl_id[i];
              r.status = lts_pkg::STAT_RANGE; // mark found
            end
            lo = lo + tbl_tk[i];
          end
          r.status = lts_pkg::STAT_OK;
          if (r.result_id == 0) begin
            // owner may legitimately have id zero after wrap: recheck by search
            lo = '0;
            for (int i = 0; i < tbl_n; i++) begin
              if (it.winning_ticket >= lo && it.winning_ticket < lo + tbl_tk[i])
                r.result_id = tbl_id[i];
              lo = lo + tbl_tk[i];
            end
          end
        end
      end
      default: ;
    endcase
    r.task_count = 7'(tbl_n);
    r.total_tickets = tbl_sum;
    return r;
  endfunction

  function automatic lts_pkg::in_item_t mk(logic [1:0] c, logic [15:0] t, logic [15:0] id,
                                           logic [21:0] w);
    lts_pkg::in_item_t it;
    it.command = c; it.tickets = t; it.task_id = id; it.winning_ticket = w;
    return it;
  endfunction

  // Driver: feed pending items, idle at random
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && !hold_feed &&
            (calm || $urandom_range(99) >= 33)) begin
          in_item <= pending_items[0];
          expected_results.push_back(schedule_step(pending_items.pop_front()));
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item %p", out_item);
          failed = 1'b1;
        end else begin
          lts_pkg::out_item_t e;
          e = expected_results.pop_front();
          if (out_item.result_id !== e.result_id) begin
            $error("result_id exp %0d got %0d", e.result_id, out_item.result_id);
            failed = 1'b1;
          end
          if (out_item.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_item.status);
            failed = 1'b1;
          end
          if (out_item.task_count !== e.task_count) begin
            $error("task_count exp %0d got %0d", e.task_count, out_item.task_count);
            failed = 1'b1;
          end
          if (out_item.total_tickets !== e.total_tickets) begin
            $error("total_tickets exp %0d got %0d", e.total_tickets, out_item.total_tickets);
            failed = 1'b1;
          end
        end
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 33);
    end
  end

  // Random id: mostly one present in the shadow table (approximated from recent ids)
  function automatic logic [15:0] pick_id();
    if ($urandom_range(99) < 80) return last_id - 16'($urandom_range(40));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_tk();
    case ($urandom_range(9))
      0: return 16'hFFFF;
      1: return 16'd0;
      2, 3: return 16'($urandom);
      default: return 16'($urandom_range(1, 64));
    endcase
  endfunction

  task automatic wait_drain();
    while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge clk);
  endtask

  initial begin
    int k;
    tbl_n = 0; tbl_sum = '0; last_id = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-table cases, extremes, full table, duplicate ids
    pending_items.push_back(mk(lts_pkg::CMD_DRAW, 16'd0, 16'd0, 22'd0));
    pending_items.push_back(mk(lts_pkg::CMD_REMOVE, 16'd0, 16'd1, 22'd0));
    pending_items.push_back(mk(CMD_NOP, 16'hFFFF, 16'hFFFF, 22'h3FFFFF));
    pending_items.push_back(mk(lts_pkg::CMD_ADD, 16'd0, 16'd0, 22'd0));
    pending_items.push_back(mk(lts_pkg::CMD_ADD, 16'd1, 16'hFFFF, 22'h3FFFFF));
    pending_items.push_back(mk(lts_pkg::CMD_ADD, 16'hFFFF, 16'd0, 22'd0));
    pending_items.push_back(mk(lts_pkg::CMD_DRAW, 16'd0, 16'd0, 22'd0));
    pending_items.push_back(mk(lts_pkg::CMD_DRAW, 16'd0, 16'd0, 22'd1));
    pending_items.push_back(mk(lts_pkg::CMD_DRAW, 16'd0, 16'd0, 22'd65536));
    pending_items.push_back(mk(lts_pkg::CMD_DRAW, 16'd0, 16'd0, 22'd65535));
    pending_items.push_back(mk(lts_pkg::CMD_DRAW, 16'd0, 16'd0, 22'h3FFFFF));
    pending_items.push_back(mk(lts_pkg::CMD_REMOVE, 16'd0, 16'd1, 22'd0));
    pending_items.push_back(mk(lts_pkg::CMD_REMOVE, 16'd0, 16'd7, 22'd0));
    for (k = 0; k < 63; k++)
      pending_items.push_back(mk(lts_pkg::CMD_ADD, 16'hFFFF, 16'd0, 22'd0));
    pending_items.push_back(mk(lts_pkg::CMD_ADD, 16'd5, 16'd0, 22'd0));
    pending_items.push_back(mk(lts_pkg::CMD_DRAW, 16'd0, 16'd0, 22'h3FFFBF));
    pending_items.push_back(mk(lts_pkg::CMD_DRAW, 16'd0, 16'd0, 22'h3FFFC0));

    // Sender pause until all results are in, then a stretch with no idling
    while (pending_items.size() > 0) @(posedge clk);
    hold_feed = 1'b1;
    for (k = 0; k < 150; k++)
      pending_items.push_back(mk(2'($urandom_range(2)), pick_tk(), pick_id(),
                                 22'($urandom_range(0, 4194239))));
    while (expected_results.size() > 0) @(posedge clk);
    hold_feed = 1'b0;
    calm = 1'b1;
    wait_drain();
    calm = 1'b0;

    // Random phase: mix of table churn, no-ops and draws with mostly small winning tickets
    for (k = 0; k < 1520; k++) begin
      lts_pkg::in_item_t it;
      it = mk(2'($urandom_range(3)), pick_tk(), pick_id(), 22'($urandom));
      if ($urandom_range(3) != 0) it.winning_ticket = 22'($urandom_range(0, 200000));
      if ($urandom_range(9) < 4)
        it.command = $urandom_range(1) ? lts_pkg::CMD_ADD : lts_pkg::CMD_DRAW;
      if (k > 800 && k < 1000 && it.command == lts_pkg::CMD_ADD)
        it.command = lts_pkg::CMD_REMOVE;
      pending_items.push_back(it);
    end
    wait_drain();
    repeat (100) @(posedge clk);
    if (!failed) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule
